[hdl/websocket_rx_frame_parser_unit_assert.svh]
// Assertion helpers for the frame parser.
// Both macros use an active-low reset in disable iff.
`ifndef WEBSOCKET_RX_FRAME_PARSER_UNIT_ASSERT_SVH
`define WEBSOCKET_RX_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WSRX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsrx assertion failed");

// Next-cycle implication.
`define WSRX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsrx assertion failed");

`endif

[hdl/wsrx_pkg.sv]
package wsrx_pkg;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_FRAGMENTED = 2'd0;
    localparam logic [1:0] ERR_CLOSE      = 2'd1;
    localparam logic [1:0] ERR_OPCODE     = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG   = 2'd3;

    // opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;

    // 7-bit length escapes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // header byte counts
    localparam logic [3:0] CNT_EXT16 = 4'd2;
    localparam logic [3:0] CNT_EXT64 = 4'd8;
    localparam logic [3:0] CNT_MASK  = 4'd4;

    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd16384;

endpackage

[hdl/websocket_rx_frame_parser_unit.sv]
// Latency: a result word is registered at the edge that accepts the causing byte and
//   shows on the outputs in the following cycle.
// Throughput: one byte per cycle; header parse and unmask are combinational logic
//   feeding the result register, so input stalls only while a held result is stalled.
// Reset: i_rst_n synchronous, active low; parser back to first header byte, error lock
//   cleared, max length limit r_max_len back to 16384.
`include "websocket_rx_frame_parser_unit_assert.svh"

module websocket_rx_frame_parser_unit
    import wsrx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // byte stream in
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // result words out
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_is_text,
    output logic        o_last_of_frame,
    output logic [1:0]  o_error_code
);

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [31:0] r_max_len;
    t_phase      r_phase,     n_phase;
    logic [3:0]  r_hdr_cnt,   n_hdr_cnt;
    // Extended length is held as its low 32 bits plus a sticky flag that
    // records any nonzero byte shifted out above bit 31.
    logic [31:0] r_len_acc,   n_len_acc;
    logic        r_len_ovf,   n_len_ovf;
    logic [31:0] r_remaining, n_remaining;
    logic [31:0] r_mask_key,  n_mask_key;
    logic [1:0]  r_mask_pos,  n_mask_pos;
    logic        r_masked,    n_masked;
    logic        r_text,      n_text;
    logic        r_err,       n_err;

    // result register
    logic        r_res_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_payload_byte;
    logic        r_is_text;
    logic        r_last;
    logic [1:0]  r_err_code;

    // result produced by the current byte
    logic        res_v;
    logic [1:0]  res_kind;
    logic [7:0]  res_byte;
    logic        res_text;
    logic        res_last;
    logic [1:0]  res_code;

    logic        rx_fire;
    logic        res_load;

    // The result register can take a new word when empty or when its word
    // leaves this cycle; the input follows the same condition.
    assign res_load   = !r_res_valid || !i_res_stall;
    assign o_rx_stall = !res_load;
    assign rx_fire    = i_rx_valid && res_load;

    // ------------------------------------------------------------------
    // Per-byte parse step
    // ------------------------------------------------------------------
    logic        fin;       // length complete, run max check
    logic [31:0] fin_len;
    logic        fin_ovf;
    logic        start;     // header complete, enter payload or emit empty
    logic [31:0] rem_dec;
    logic [7:0]  key_byte;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_len_acc   = r_len_acc;
        n_len_ovf   = r_len_ovf;
        n_remaining = r_remaining;
        n_mask_key  = r_mask_key;
        n_mask_pos  = r_mask_pos;
        n_masked    = r_masked;
        n_text      = r_text;
        n_err       = r_err;
        res_v       = 1'b0;
        res_kind    = KIND_PAYLOAD;
        res_byte    = 8'd0;
        res_text    = 1'b0;
        res_last    = 1'b0;
        res_code    = ERR_FRAGMENTED;
        fin         = 1'b0;
        fin_len     = 32'd0;
        fin_ovf     = 1'b0;
        start       = 1'b0;
        rem_dec     = r_remaining - 32'd1;

        case (r_mask_pos)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase

        if (rx_fire && !r_err) begin
            case (r_phase)
                PH_HDR1: begin
                    n_masked  = i_rx_byte[7];
                    n_len_acc = 32'd0;
                    n_len_ovf = 1'b0;
                    if (i_rx_byte[6:0] == LEN_EXT16) begin
                        n_phase   = PH_EXTLEN;
                        n_hdr_cnt = CNT_EXT16;
                    end else if (i_rx_byte[6:0] == LEN_EXT64) begin
                        n_phase   = PH_EXTLEN;
                        n_hdr_cnt = CNT_EXT64;
                    end else begin
                        n_len_acc = {25'd0, i_rx_byte[6:0]};
                        fin       = 1'b1;
                        fin_len   = {25'd0, i_rx_byte[6:0]};
                    end
                end
                PH_EXTLEN: begin
                    n_len_ovf = r_len_ovf || (r_len_acc[31:24] != 8'd0);
                    n_len_acc = {r_len_acc[23:0], i_rx_byte};
                    n_hdr_cnt = r_hdr_cnt - 4'd1;
                    if (n_hdr_cnt == 4'd0) begin
                        fin     = 1'b1;
                        fin_len = n_len_acc;
                        fin_ovf = n_len_ovf;
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_rx_byte};
                    n_hdr_cnt  = r_hdr_cnt - 4'd1;
                    if (n_hdr_cnt == 4'd0) begin
                        start = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_mask_pos  = r_mask_pos + 2'd1;
                    n_remaining = rem_dec;
                    if (rem_dec == 32'd0) begin
                        n_phase = PH_HDR0;
                    end
                    res_v    = 1'b1;
                    res_kind = KIND_PAYLOAD;
                    res_byte = i_rx_byte ^ key_byte;
                    res_text = r_text;
                    res_last = (rem_dec == 32'd0);
                end
                default: begin
                    // first header byte; unused codes land here too
                    if (!i_rx_byte[7]) begin
                        n_err    = 1'b1;
                        n_phase  = PH_HDR0;
                        res_v    = 1'b1;
                        res_kind = KIND_ERROR;
                        res_code = ERR_FRAGMENTED;
                    end else if (i_rx_byte[3:0] == OP_TEXT || i_rx_byte[3:0] == OP_BINARY) begin
                        n_text      = (i_rx_byte[3:0] == OP_TEXT);
                        n_masked    = 1'b0;
                        n_mask_key  = 32'd0;
                        n_mask_pos  = 2'd0;
                        n_hdr_cnt   = 4'd0;
                        n_len_acc   = 32'd0;
                        n_len_ovf   = 1'b0;
                        n_remaining = 32'd0;
                        n_phase     = PH_HDR1;
                    end else begin
                        n_err    = 1'b1;
                        n_phase  = PH_HDR0;
                        res_v    = 1'b1;
                        res_kind = KIND_ERROR;
                        res_code = (i_rx_byte[3:0] == OP_CLOSE) ? ERR_CLOSE : ERR_OPCODE;
                    end
                end
            endcase

            // length check against the live maximum
            if (fin) begin
                if (fin_ovf || (fin_len > r_max_len)) begin
                    n_err    = 1'b1;
                    n_phase  = PH_HDR0;
                    res_v    = 1'b1;
                    res_kind = KIND_ERROR;
                    res_code = ERR_TOO_LONG;
                end else begin
                    n_remaining = fin_len;
                    if (n_masked) begin
                        n_phase   = PH_MASK;
                        n_hdr_cnt = CNT_MASK;
                    end else begin
                        start = 1'b1;
                    end
                end
            end

            // header done: zero length gives a single empty-frame word
            if (start) begin
                n_mask_pos = 2'd0;
                if (n_remaining == 32'd0) begin
                    n_phase  = PH_HDR0;
                    res_v    = 1'b1;
                    res_kind = KIND_EMPTY;
                    res_text = r_text;
                    res_last = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_PAYLOAD_RST;
            r_phase     <= PH_HDR0;
            r_hdr_cnt   <= 4'd0;
            r_len_acc   <= 32'd0;
            r_len_ovf   <= 1'b0;
            r_remaining <= 32'd0;
            r_mask_key  <= 32'd0;
            r_mask_pos  <= 2'd0;
            r_masked    <= 1'b0;
            r_text      <= 1'b0;
            r_err       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_len_acc   <= n_len_acc;
            r_len_ovf   <= n_len_ovf;
            r_remaining <= n_remaining;
            r_mask_key  <= n_mask_key;
            r_mask_pos  <= n_mask_pos;
            r_masked    <= n_masked;
            r_text      <= n_text;
            r_err       <= n_err;
            if (res_load) begin
                r_res_valid <= res_v;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (res_load && res_v) begin
            r_kind         <= res_kind;
            r_payload_byte <= res_byte;
            r_is_text      <= res_text;
            r_last         <= res_last;
            r_err_code     <= res_code;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_kind          = r_kind;
    assign o_payload_byte  = r_payload_byte;
    assign o_is_text       = r_is_text;
    assign o_last_of_frame = r_last;
    assign o_error_code    = r_err_code;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WSRX_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err, r_err)
    `WSRX_ASSERT_NEXT(a_no_word_after_lock, i_clk, i_rst_n,
        r_err && !(r_res_valid && i_res_stall), !r_res_valid)
    `WSRX_ASSERT_NOW(a_error_word_locks, i_clk, i_rst_n,
        r_res_valid && r_kind == KIND_ERROR, r_err)
    `WSRX_ASSERT_NOW(a_payload_nonzero, i_clk, i_rst_n,
        r_phase == PH_PAYLOAD, r_remaining != 32'd0)
    `WSRX_ASSERT_NOW(a_extlen_count, i_clk, i_rst_n,
        r_phase == PH_EXTLEN, r_hdr_cnt != 4'd0 && r_hdr_cnt <= CNT_EXT64)

endmodule

[sim/tb_websocket_rx_frame_parser_unit.sv]
module tb_websocket_rx_frame_parser_unit;
    import wsrx_pkg::*;

    // Generous bound for ~1900 bytes, even with both sides stalling.
    localparam int CYCLE_LIMIT = 150000;
    localparam int BYTE_TARGET = 1850;

    // One result word as it leaves the parser.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       text;
        logic       last;
        logic [1:0] code;
    } t_word;

    // How the payload length is spelled in the header.
    typedef enum int {ENC_DIRECT, ENC_EXT16, ENC_EXT64} t_len_enc;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_rx_valid    = 1'b0;
    logic [7:0]  i_rx_byte     = '0;
    logic        i_res_stall   = 1'b0;
    logic        o_rx_stall;
    logic        o_res_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic        o_is_text;
    logic        o_last_of_frame;
    logic [1:0]  o_error_code;

    websocket_rx_frame_parser_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_rx_valid      (i_rx_valid),
        .o_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_kind          (o_kind),
        .o_payload_byte  (o_payload_byte),
        .o_is_text       (o_is_text),
        .o_last_of_frame (o_last_of_frame),
        .o_error_code    (o_error_code)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stream bytes waiting to be driven, and result words the parser still owes.
    logic [7:0]  rx_bytes_q[$];
    t_word       due_words[$];

    int          gap_pct = 38;      // idle/stall chance per cycle, both sides
    logic        rx_taken = 1'b0;   // byte on the bus was accepted at the last edge
    int          cycle_count = 0;
    int          mismatches = 0;
    int          queued_total = 0;
    int          bytes_sent = 0;
    int          n_payload = 0;
    int          n_empty = 0;
    int          n_error = 0;
    logic [1:0]  err_pick;

    // ---------------------------------------------------------------
    // Frame parser shadow: its own state and limit register.
    // ---------------------------------------------------------------
    t_phase      ph = PH_HDR0;
    logic [3:0]  hdr_cnt = '0;
    logic [63:0] len_acc = '0;
    logic [31:0] remain = '0;
    logic [31:0] mkey = '0;
    logic [1:0]  mpos = '0;
    logic        masked = 1'b0;
    logic        text_frame = 1'b0;
    logic        locked = 1'b0;
    logic [31:0] max_len = MAX_PAYLOAD_RST;

    // First error locks the parser for good.
    function automatic bit raise_err(input logic [1:0] code, output t_word w);
        locked = 1'b1;
        ph = PH_HDR0;
        w = {KIND_ERROR, 8'h00, 1'b0, 1'b0, code};
        return 1'b1;
    endfunction

    // Header done: a zero length yields the empty-frame word right away.
    function automatic bit open_payload(output t_word w);
        w = '0;
        mpos = '0;
        if (remain == 32'd0) begin
            ph = PH_HDR0;
            w = {KIND_EMPTY, 8'h00, text_frame, 1'b1, ERR_FRAGMENTED};
            return 1'b1;
        end
        ph = PH_PAYLOAD;
        return 1'b0;
    endfunction

    // Full 64-bit length against the limit in force right now.
    function automatic bit close_length(output t_word w);
        w = '0;
        if (len_acc > {32'd0, max_len})
            return raise_err(ERR_TOO_LONG, w);
        remain = len_acc[31:0];
        if (masked) begin
            ph = PH_MASK;
            hdr_cnt = CNT_MASK;
            return 1'b0;
        end
        return open_payload(w);
    endfunction

    // Advances the shadow by one stream byte; returns 1 when a word is due.
    function automatic bit parse_rx_byte(input logic [7:0] b, output t_word w);
        logic [7:0] kb;
        w = '0;
        if (locked)
            return 1'b0;
        case (ph)
            PH_HDR1: begin
                masked = b[7];
                len_acc = '0;
                if (b[6:0] == LEN_EXT16) begin
                    ph = PH_EXTLEN;
                    hdr_cnt = CNT_EXT16;
                    return 1'b0;
                end
                if (b[6:0] == LEN_EXT64) begin
                    ph = PH_EXTLEN;
                    hdr_cnt = CNT_EXT64;
                    return 1'b0;
                end
                len_acc = {57'd0, b[6:0]};
                return close_length(w);
            end
            PH_EXTLEN: begin
                len_acc = {len_acc[55:0], b};   // big-endian
                hdr_cnt = hdr_cnt - 4'd1;
                if (hdr_cnt != 4'd0)
                    return 1'b0;
                return close_length(w);
            end
            PH_MASK: begin
                mkey = {mkey[23:0], b};
                hdr_cnt = hdr_cnt - 4'd1;
                if (hdr_cnt != 4'd0)
                    return 1'b0;
                return open_payload(w);
            end
            PH_PAYLOAD: begin
                kb = mkey[8 * (3 - mpos) +: 8];  // key bytes taken MSB first
                mpos = mpos + 2'd1;
                remain = remain - 32'd1;
                if (remain == 32'd0)
                    ph = PH_HDR0;
                w = {KIND_PAYLOAD, b ^ kb, text_frame, remain == 32'd0, ERR_FRAGMENTED};
                return 1'b1;
            end
            default: begin
                // first header byte: FIN, then opcode
                if (!b[7])
                    return raise_err(ERR_FRAGMENTED, w);
                if (b[3:0] == OP_CLOSE)
                    return raise_err(ERR_CLOSE, w);
                if (b[3:0] != OP_TEXT && b[3:0] != OP_BINARY)
                    return raise_err(ERR_OPCODE, w);
                text_frame = (b[3:0] == OP_TEXT);
                masked = 1'b0;
                mkey = '0;
                mpos = '0;
                hdr_cnt = '0;
                len_acc = '0;
                remain = '0;
                ph = PH_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        queued_total++;
    endtask

    // Header only; RSV bits random since the parser ignores them.
    task automatic push_header(input bit text, input bit msk, input logic [63:0] len64,
                               input t_len_enc enc, input logic [31:0] key);
        push_byte({1'b1, 3'($urandom_range(7)), text ? OP_TEXT : OP_BINARY});
        case (enc)
            ENC_DIRECT: push_byte({msk, len64[6:0]});
            ENC_EXT16: begin
                push_byte({msk, LEN_EXT16});
                push_byte(len64[15:8]);
                push_byte(len64[7:0]);
            end
            default: begin
                push_byte({msk, LEN_EXT64});
                for (int k = 7; k >= 0; k--)
                    push_byte(len64[8 * k +: 8]);
            end
        endcase
        if (msk)
            for (int k = 3; k >= 0; k--)
                push_byte(key[8 * k +: 8]);
    endtask

    // Whole frame; payload leans on 00/FF now and then.
    task automatic push_frame(input bit text, input bit msk, input int unsigned len,
                              input t_len_enc enc, input logic [31:0] key);
        push_header(text, msk, 64'(len), enc, key);
        for (int unsigned n = 0; n < len; n++)
            push_byte(($urandom_range(7) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom));
    endtask

    // Legal frame within the current limit, mostly short.
    task automatic push_random_frame();
        int unsigned len;
        int unsigned pick;
        t_len_enc    enc;
        logic [31:0] key;
        pick = $urandom_range(99);
        if (pick < 10)
            len = 0;
        else if (pick < 75)
            len = $urandom_range(12, 1);
        else if (pick < 95)
            len = $urandom_range(60, 13);
        else
            len = $urandom_range(140, 61);
        if (max_len < 200 && $urandom_range(4) == 0)
            len = max_len;                  // right on the limit
        if (len > max_len)
            len = $urandom_range(max_len);
        pick = $urandom_range(99);
        if (len > 125)
            enc = (pick < 60) ? ENC_EXT16 : ENC_EXT64;
        else
            enc = (pick < 60) ? ENC_DIRECT : (pick < 85) ? ENC_EXT16 : ENC_EXT64;
        key = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom);
        push_frame($urandom_range(1), $urandom_range(1), len, enc, key);
    endtask

    task automatic fill_frames_to(input int n);
        while (queued_total < n)
            push_random_frame();
    endtask

    // Sender has nothing left, parser owes nothing; then let the pipe settle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (rx_bytes_q.size() != 0 || i_rx_valid || due_words.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called while idle, so the shadow limit can switch at once.
    task automatic set_max_len(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        max_len = v;
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[cycle %0d] mismatch: %s", cycle_count, what);
    endtask

    // ---------------------------------------------------------------
    // Driver: new byte or idle at the falling edge, only once the
    // current one is gone. Receiver stall is drawn here as well.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rx_valid || rx_taken) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= rx_bytes_q.pop_front();
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
        i_res_stall <= ($urandom_range(99) < gap_pct);
    end

    // Accepted byte -> shadow parse -> word owed. Also the watchdog.
    always @(posedge i_clk) begin
        t_word w;
        rx_taken <= i_rst_n && i_rx_valid && (o_rx_stall === 1'b0);
        if (i_rst_n && i_rx_valid && o_rx_stall === 1'b0) begin
            bytes_sent++;
            if (parse_rx_byte(i_rx_byte, w))
                due_words.push_back(w);
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed",
                     cycle_count, due_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Monitor: every accepted word against the oldest one owed.
    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            got = {o_kind, o_payload_byte, o_is_text, o_last_of_frame, o_error_code};
            if (due_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind=%0d data=%02h",
                                          got.kind, got.data));
            end else begin
                want = due_words.pop_front();
                if (got !== want)
                    report_mismatch({
                        $sformatf("got kind=%0d data=%02h text=%b last=%b code=%0d",
                                  got.kind, got.data, got.text, got.last, got.code),
                        $sformatf(", want kind=%0d data=%02h text=%b last=%b code=%0d",
                                  want.kind, want.data, want.text, want.last, want.code)});
            end
            case (got.kind)
                KIND_PAYLOAD: n_payload++;
                KIND_EMPTY:   n_empty++;
                default:      n_error++;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [3:0] op;
        int unsigned pick;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, limit at reset value: empty frame, masked frame whose key
        // wraps around, 64-bit length spelling, masked empty frame.
        push_frame(1'b1, 1'b0, 0, ENC_DIRECT, 32'd0);
        push_frame(1'b0, 1'b1, 5, ENC_DIRECT, 32'h8001_FF7E);
        push_frame(1'b1, 1'b0, 1, ENC_EXT64, 32'd0);
        push_frame(1'b0, 1'b1, 0, ENC_EXT16, 32'hFFFF_FFFF);
        fill_frames_to(300);
        wait_idle();

        // Limit wide open.
        set_max_len(32'hFFFF_FFFF);
        fill_frames_to(650);
        wait_idle();

        // Limit zero: only empty frames pass.
        set_max_len(32'd0);
        fill_frames_to(710);
        wait_idle();

        // Tiny limit, no idling on either side for a long stretch.
        set_max_len(32'($urandom_range(16, 1)));
        gap_pct = 0;
        fill_frames_to(1250);
        wait_idle();

        // Moderate limit, then end the stream with one error of a random kind.
        gap_pct = 38;
        set_max_len(32'($urandom_range(124, 20)));
        fill_frames_to(BYTE_TARGET);
        err_pick = 2'($urandom_range(3));
        case (err_pick)
            ERR_FRAGMENTED: push_byte({1'b0, 7'($urandom)});
            ERR_CLOSE:      push_byte({1'b1, 3'($urandom), OP_CLOSE});
            ERR_OPCODE: begin
                do op = 4'($urandom);
                while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE);
                push_byte({1'b1, 3'($urandom), op});
            end
            default: begin
                // one past the limit in any spelling, or a length beyond 32 bits
                pick = $urandom_range(3);
                if (pick == 3)
                    push_header($urandom_range(1), $urandom_range(1),
                                {32'($urandom_range(32'hFFFF_FFFF, 1)), 32'($urandom)},
                                ENC_EXT64, 32'($urandom));
                else
                    push_header($urandom_range(1), $urandom_range(1),
                                64'(max_len) + 64'd1, t_len_enc'(pick), 32'($urandom));
            end
        endcase
        // locked now: these must produce nothing
        repeat (8) push_byte(8'($urandom));
        wait_idle();

        $display("Stream of %0d bytes: %0d payload, %0d empty, %0d error words.",
                 bytes_sent, n_payload, n_empty, n_error);
        $display("Limits: reset, all ones, zero, two small random; closing error code %0d.",
                 err_pick);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/wsrx_pkg.sv
hdl/websocket_rx_frame_parser_unit.sv
sim/tb_websocket_rx_frame_parser_unit.sv
